/* src/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned MAX_FREE_BLOCKS = 64;
  // power of two, rounding is a mask
  localparam int unsigned ALIGN_BYTES     = 16;
  localparam int unsigned IDX_W           = $clog2(MAX_FREE_BLOCKS);
  localparam int unsigned CNT_W           = $clog2(MAX_FREE_BLOCKS + 1);
  localparam int unsigned LEN_W           = 25;
  localparam int unsigned OFF_W           = 24;
  localparam int unsigned OUT_CNT_W       = 7;
  localparam int unsigned CAP_MIN         = 4;
  localparam int unsigned CAP_MAX         = 16777216;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_INVALID = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_F_RD,
    S_F_CHK,
    S_F_DEC,
    S_RM_RD,
    S_RM_WR,
    S_IN_RD,
    S_IN_WR,
    S_IN_NEW,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] len;
  } ent_t;

endpackage

/* src/ffba_ram.sv */
// ----------------------------------------------------------------------------
// ffba_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/first_fit_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// first-fit free list allocator with coalescing, free list kept in a ram
// ----------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o | mode, length, block_offset
// out     | output    | out_valid_o / out_stall_i | status .. free_block_count
// cfg     | input     | cfg_valid_i / cfg_ready_o | capacity
//
// an item visits free list entries one at a time in the scan, and moves entries
// one at a time when an entry is removed or inserted, since each entry goes
// through the single read port of the ram, whose read is registered.
// errors caught at the input go straight to the finish state.
// reset and a capacity write rebuild the list at once, no clearing pass.
// a finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [ffba_pkg::LEN_W-1:0]    length_i,
  input  logic [ffba_pkg::OFF_W-1:0]    block_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [ffba_pkg::OFF_W-1:0]    granted_offset_o,
  output logic [ffba_pkg::LEN_W-1:0]    granted_size_o,
  output logic [ffba_pkg::LEN_W-1:0]    used_bytes_o,
  output logic [ffba_pkg::LEN_W-1:0]    high_water_o,
  output logic [ffba_pkg::OUT_CNT_W-1:0] free_block_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffba_pkg::LEN_W-1:0]    capacity_i
);
  import ffba_pkg::*;

  localparam logic [LEN_W:0]   ALIGN_M = (LEN_W + 1)'(ALIGN_BYTES - 1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FREE_BLOCKS);

  state_e state_q, state_d;

  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] off_q;
  logic [LEN_W:0]   need_q;
  logic [CNT_W-1:0] idx_q, j_q, cnt_q;
  logic [LEN_W-1:0] used_q, peak_q, cap_q;
  logic             e0_q, e0sel_q;
  ent_t             prev_q, right_q;
  logic             has_left_q, has_right_q;
  status_e          st_q;
  logic [OFF_W-1:0] goff_q;
  logic [LEN_W-1:0] gsz_q;

  logic             out_valid_q;
  logic [2:0]       out_st_q;
  logic [OFF_W-1:0] out_goff_q;
  logic [LEN_W-1:0] out_gsz_q, out_used_q, out_peak_q;
  logic [OUT_CNT_W-1:0] out_cnt_q;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  ent_t             ram_wdata, ram_rdata, rd;

  logic             in_acc, cfg_acc, out_load;
  logic [CNT_W-1:0] idx_p1, idx_p2, idx_m1;
  logic [LEN_W:0]   left_end, need_in;
  logic [LEN_W-1:0] end_q;
  logic             bad_free, jl, jr, fit, exact;
  logic [LEN_W-1:0] cap_clamp;

  ffba_ram #(.W($bits(ent_t)), .D(MAX_FREE_BLOCKS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd = e0sel_q ? ent_t'{start: '0, len: cap_q} : ram_rdata;

  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  assign idx_p1   = idx_q + CNT_ONE;
  assign idx_p2   = idx_q + CNT_W'(2);
  assign idx_m1   = idx_q - CNT_ONE;
  assign need_in  = ({1'b0, length_i} + ALIGN_M) & ~ALIGN_M;
  assign end_q    = off_q + len_q;
  assign left_end = {1'b0, prev_q.start} + {1'b0, prev_q.len};
  assign jl       = has_left_q && (left_end == {1'b0, off_q});
  assign jr       = has_right_q && (right_q.start == end_q);
  assign fit      = {1'b0, rd.len} >= need_q;
  assign exact    = {1'b0, rd.len} == need_q;
  assign bad_free = (length_i == '0)
                 || (({1'b0, block_offset_i} + {1'b0, length_i}) > {1'b0, cap_q})
                 || (length_i > used_q);
  assign cap_clamp = (capacity_i < LEN_W'(CAP_MIN)) ? LEN_W'(CAP_MIN) :
                     (capacity_i > LEN_W'(CAP_MAX)) ? LEN_W'(CAP_MAX) : capacity_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[IDX_W-1:0];
    ram_wdata = rd;
    ram_raddr = idx_q[IDX_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!mode_i) begin
            state_d = ((length_i == '0) || (cnt_q == '0)) ? S_FIN : S_A_RD;
          end else if (bad_free) begin
            state_d = S_FIN;
          end else begin
            state_d = (cnt_q == '0) ? S_F_DEC : S_F_RD;
          end
        end
      end
      S_A_RD: state_d = S_A_CHK;
      S_A_CHK: begin
        if (fit) begin
          if (exact) begin
            state_d = (idx_p1 < cnt_q) ? S_RM_RD : S_FIN;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ent_t'{start: rd.start + need_q[LEN_W-1:0],
                               len:   rd.len - need_q[LEN_W-1:0]};
            state_d   = S_FIN;
          end
        end else begin
          state_d = (idx_p1 < cnt_q) ? S_A_RD : S_FIN;
        end
      end
      S_F_RD: state_d = S_F_CHK;
      S_F_CHK: begin
        if (rd.start < off_q) begin
          state_d = (idx_p1 < cnt_q) ? S_F_RD : S_F_DEC;
        end else begin
          state_d = S_F_DEC;
        end
      end
      S_F_DEC: begin
        if ((has_left_q && (left_end > {1'b0, off_q}))
            || (has_right_q && (right_q.start < end_q))) begin
          state_d = S_FIN;
        end else if (jl) begin
          ram_we    = 1'b1;
          ram_waddr = idx_m1[IDX_W-1:0];
          ram_wdata = ent_t'{start: prev_q.start,
                             len: prev_q.len + len_q + (jr ? right_q.len : '0)};
          state_d   = (jr && (idx_p1 < cnt_q)) ? S_RM_RD : S_FIN;
        end else if (jr) begin
          ram_we    = 1'b1;
          ram_wdata = ent_t'{start: off_q, len: right_q.len + len_q};
          state_d   = S_FIN;
        end else if (cnt_q >= CNT_MAX) begin
          state_d = S_FIN;
        end else begin
          state_d = (idx_q < cnt_q) ? S_IN_RD : S_IN_NEW;
        end
      end
      S_RM_RD: begin
        ram_raddr = idx_p1[IDX_W-1:0];
        state_d   = S_RM_WR;
      end
      S_RM_WR: begin
        ram_we  = 1'b1;
        state_d = (idx_p2 < cnt_q) ? S_RM_RD : S_FIN;
      end
      S_IN_RD: begin
        ram_raddr = j_q[IDX_W-1:0];
        state_d   = S_IN_WR;
      end
      S_IN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(j_q + CNT_ONE);
        state_d   = (j_q == idx_q) ? S_IN_NEW : S_IN_RD;
      end
      S_IN_NEW: begin
        ram_we    = 1'b1;
        ram_wdata = ent_t'{start: off_q, len: len_q};
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= CNT_ONE;
      used_q  <= '0;
      peak_q  <= '0;
      cap_q   <= LEN_W'(CAP_MIN);
      e0_q    <= 1'b1;
      e0sel_q <= 1'b0;
    end else begin
      e0sel_q <= e0_q && (ram_raddr == '0);
      if (ram_we && (ram_waddr == '0)) begin
        e0_q <= 1'b0;
      end
      if (cfg_acc) begin
        cap_q  <= cap_clamp;
        cnt_q  <= CNT_ONE;
        used_q <= '0;
        peak_q <= '0;
        e0_q   <= 1'b1;
      end
      unique case (state_q)
        S_A_CHK: begin
          if (fit) begin
            used_q <= used_q + need_q[LEN_W-1:0];
            if ((rd.start + need_q[LEN_W-1:0]) > peak_q) begin
              peak_q <= rd.start + need_q[LEN_W-1:0];
            end
            if (exact && !(idx_p1 < cnt_q)) begin
              cnt_q <= cnt_q - CNT_ONE;
            end
          end
        end
        S_F_DEC: begin
          if (!((has_left_q && (left_end > {1'b0, off_q}))
                || (has_right_q && (right_q.start < end_q)))) begin
            if (jl || jr) begin
              used_q <= used_q - len_q;
              if (jl && jr && !(idx_p1 < cnt_q)) begin
                cnt_q <= cnt_q - CNT_ONE;
              end
            end else if (cnt_q < CNT_MAX) begin
              used_q <= used_q - len_q;
            end
          end
        end
        S_RM_WR: begin
          if (!(idx_p2 < cnt_q)) begin
            cnt_q <= cnt_q - CNT_ONE;
          end
        end
        S_IN_NEW: cnt_q <= cnt_q + CNT_ONE;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        len_q       <= length_i;
        off_q       <= {1'b0, block_offset_i};
        need_q      <= need_in;
        idx_q       <= '0;
        has_left_q  <= 1'b0;
        has_right_q <= 1'b0;
        goff_q      <= '0;
        gsz_q       <= '0;
        if (!mode_i) begin
          st_q <= (length_i == '0) ? ST_ZERO : ST_NOSPACE;
        end else begin
          st_q <= bad_free ? ST_INVALID : ST_OK;
        end
      end
      S_A_CHK: begin
        if (fit) begin
          st_q   <= ST_OK;
          goff_q <= rd.start[OFF_W-1:0];
          gsz_q  <= need_q[LEN_W-1:0];
        end else begin
          idx_q <= idx_p1;
        end
      end
      S_F_CHK: begin
        if (rd.start < off_q) begin
          prev_q     <= rd;
          has_left_q <= 1'b1;
          idx_q      <= idx_p1;
        end else begin
          right_q     <= rd;
          has_right_q <= 1'b1;
        end
      end
      S_F_DEC: begin
        j_q <= cnt_q - CNT_ONE;
        if ((has_left_q && (left_end > {1'b0, off_q}))
            || (has_right_q && (right_q.start < end_q))) begin
          st_q <= ST_INVALID;
        end else if (!(jl || jr) && (cnt_q >= CNT_MAX)) begin
          st_q <= ST_FULL;
        end
      end
      S_RM_WR: idx_q <= idx_p1;
      S_IN_WR: j_q <= j_q - CNT_ONE;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_st_q   <= st_q;
      out_goff_q <= goff_q;
      out_gsz_q  <= gsz_q;
      out_used_q <= used_q;
      out_peak_q <= peak_q;
      out_cnt_q  <= OUT_CNT_W'(cnt_q);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_st_q;
  assign granted_offset_o   = out_goff_q;
  assign granted_size_o     = out_gsz_q;
  assign used_bytes_o       = out_used_q;
  assign high_water_o       = out_peak_q;
  assign free_block_count_o = out_cnt_q;

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input taken while busy");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("free list count overflow");
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("ram write while idle");
  a_used_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (used_q <= cap_q))
    else $error("used bytes exceed capacity");
`endif

endmodule
